// ----- hdl/pbat_pkg.sv -----
// Package for the package block address translator: config struct,
// register indexes, table spans and reciprocal constants.
// No dependencies.
`default_nettype none

package pbat_pkg;

	localparam int unsigned IN_W      = 24;
	localparam int unsigned OUT_W     = 104;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned CFG_DAT_W = 32;
	localparam int unsigned BLK_W     = 25;
	localparam int unsigned OFS_W     = 38;

	localparam logic [23:0] SPAN0 = 24'h0000AA;
	localparam logic [23:0] SPAN1 = 24'h0070E4;
	localparam logic [23:0] SPAN2 = 24'h4AF768;

	localparam logic [24:0] BLOCK_LIMIT = 25'h0FFFFFF;
	localparam logic [24:0] SPACING_ONE = 25'h00000AB;
	localparam logic [24:0] SPACING_TWO = 25'h00000AC;

	localparam logic [31:0] HDR_ROUND  = 32'h0000_0FFF;
	localparam logic [31:0] SHIFT_MASK = 32'h0000_B000;
	localparam logic [11:0] REC_BYTES  = 12'h018;

	// floor(x / d) == (x * M) >> K for every 24-bit x
	localparam logic [24:0] MAGIC0 = 25'd25264514;
	localparam logic [24:0] MAGIC1 = 25'd19022693;
	localparam logic [23:0] MAGIC2 = 24'd14322969;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEADER_BYTES     = 8'd0,
		REG_IS_CON_PACKAGE   = 8'd1,
		REG_SEPARATION_BIT   = 8'd2,
		REG_HASH_TABLE_SHIFT = 8'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0] header_bytes;
		logic        is_con_package;
		logic        separation_bit;
		logic        hash_table_shift;
	} cfg_t;

endpackage

`default_nettype wire

// ----- hdl/package_block_address_translator.sv -----
// Top level of the package block address translator.
// Depends on pbat_pkg.
//
// channel  dir  handshake            payload
// s_       in   s_tvalid/s_tready    s_tdata: logical_block
// m_       out  m_tvalid/m_tready    m_tdata: physical_block .. record_offset_valid
// cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One beat per cycle sustained while m_tready stays high; a result beat passes through
// the input register, reciprocal multipliers into the stage-2 register, and sum/offset
// logic into the output register.
// arst_n clears all valid bits and the config registers.
// A stall on m_ backs up stage by stage; empty stages still fill.
// cfg_ready is always high.
`default_nettype none

module package_block_address_translator
	import pbat_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [IN_W-1:0]      s_tdata,   // [23:0] logical_block
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// [24:0] physical_block, [62:25] data_byte_offset, [63] data_offset_valid,
	// [101:64] record_byte_offset, [102] record_offset_valid, [103] zero
	output logic [OUT_W-1:0]          m_tdata,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data
);

	cfg_t cfg_q;

	logic        v_s1, v_s2, v_q;
	logic [23:0] l_s1, l_s2;
	logic [16:0] q0_s2;
	logic [9:0]  q1_s2;
	logic [1:0]  q2_s2;
	logic [OUT_W-1:0] data_q;

	logic rdy_q, rdy_s2;

	// config
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_HEADER_BYTES:     cfg_q.header_bytes     <= cfg_data;
				REG_IS_CON_PACKAGE:   cfg_q.is_con_package   <= cfg_data[0];
				REG_SEPARATION_BIT:   cfg_q.separation_bit   <= cfg_data[0];
				REG_HASH_TABLE_SHIFT: cfg_q.hash_table_shift <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// flow control
	assign rdy_q    = !v_q || m_tready;
	assign rdy_s2   = !v_s2 || rdy_q;
	assign s_tready = !v_s1 || rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_q  <= 1'b0;
		end else begin
			if (s_tready) v_s1 <= s_tvalid;
			if (rdy_s2)   v_s2 <= v_s1;
			if (rdy_q)    v_q  <= v_s2;
		end
	end

	// stage 1: reciprocal multiplies
	logic [48:0] p0, p1;
	logic [47:0] p2;

	assign p0 = 49'(l_s1) * 49'(MAGIC0);
	assign p1 = 49'(l_s1) * 49'(MAGIC1);
	assign p2 = 48'(l_s1) * 48'(MAGIC2);

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) l_s1 <= s_tdata[23:0];
		if (rdy_s2 && v_s1) begin
			l_s2  <= l_s1;
			q0_s2 <= p0[48:32];
			q1_s2 <= p1[48:39];
			q2_s2 <= p2[47:46];
		end
	end

	// stage 2: block numbers and byte offsets
	logic [31:0]      hdr_r;
	logic             dbl, sh, hts, ge0, ge1;
	logic [24:0]      n0, n1, n2, phys, tbl, spacing, ext1, ext2;
	logic [23:0]      rem;
	logic [11:0]      rec_ofs;
	logic [OFS_W-1:0] base, data_ofs, rec_ofs_full;
	logic             dv, rv;

	assign hdr_r = cfg_q.header_bytes + HDR_ROUND;
	assign dbl   = ((hdr_r & SHIFT_MASK) == SHIFT_MASK) || !cfg_q.separation_bit;
	assign sh    = cfg_q.is_con_package && dbl;
	assign hts   = cfg_q.hash_table_shift;
	assign ge0   = l_s2 >= SPAN0;
	assign ge1   = l_s2 >= SPAN1;

	assign n0 = (25'(q0_s2) + 25'd1) << sh;
	assign n1 = (25'(q1_s2) + 25'd1) << sh;
	assign n2 = (25'(q2_s2) + 25'd1) << sh;

	assign phys = 25'(l_s2) + n0 + (ge0 ? n1 : '0) + (ge1 ? n2 : '0);

	assign spacing = hts ? SPACING_TWO : SPACING_ONE;
	assign ext1    = (25'(q1_s2) + 25'd1) << hts;
	assign ext2    = 25'd1 << hts;
	assign tbl     = 25'(q0_s2) * spacing + (ge0 ? ext1 : '0) + (ge1 ? ext2 : '0);

	assign rem     = l_s2 - 24'(q0_s2) * SPAN0;
	assign rec_ofs = 12'(rem[7:0]) * REC_BYTES;

	assign base         = {22'd0, hdr_r[15:12], 12'd0};
	assign dv           = phys < BLOCK_LIMIT;
	assign rv           = tbl < BLOCK_LIMIT;
	assign data_ofs     = dv ? base + {1'b0, phys, 12'd0} : '0;
	assign rec_ofs_full = rv ? base + {1'b0, tbl, 12'd0} + 38'(rec_ofs) : '0;

	always_ff @(posedge clk) begin
		if (rdy_q && v_s2) begin
			data_q <= {1'b0, rv, rec_ofs_full, dv, data_ofs, phys};
		end
	end

	assign m_tvalid = v_q;
	assign m_tdata  = data_q;

endmodule

`default_nettype wire

// ----- hdl/pbat_checker.sv -----
// Port-level checker for the package block address translator, and its bind.
// Depends on pbat_pkg and package_block_address_translator.
`default_nettype none

module pbat_checker
	import pbat_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [OUT_W-1:0]     m_tdata
);

	a_m_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	a_m_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result beat changed while stalled");

	a_data_inv: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[63] |-> m_tdata[62:25] == 38'd0)
		else $error("invalid data offset not zero");

	a_rec_inv: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[102] |-> m_tdata[101:64] == 38'd0)
		else $error("invalid record offset not zero");

	a_data_align: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[36:25] == 12'd0 && m_tdata[103] == 1'b0)
		else $error("data offset not block aligned");

endmodule

bind package_block_address_translator pbat_checker u_pbat_checker (.*);

`default_nettype wire

// ----- tb/tb_package_block_address_translator.sv -----
// Self-checking testbench for package_block_address_translator.
// Drives logical block numbers through several register settings and checks each
// result beat against its own translation. Depends on pbat_pkg and the DUT.
`default_nettype none

module tb_package_block_address_translator;
	import pbat_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned ITEMS_PER_SET = 60;
	localparam int unsigned NUM_SETTINGS  = 12;
	localparam int unsigned LONG_HOLD     = 300;
	localparam int unsigned MAX_REPORTS   = 10;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd9;

	// low bits first: block, data offset, data ok, record offset, record ok
	typedef struct packed {
		logic        rec_ok;
		logic [37:0] rec_ofs;
		logic        data_ok;
		logic [37:0] data_ofs;
		logic [24:0] blk;
	} xlat_t;

	typedef struct {
		logic [23:0] lb;
		bit          typed;
		xlat_t       want;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata = '0;      // [23:0] logical_block
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_W-1:0]     m_tdata;           // block, data ofs/ok, record ofs/ok
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	cfg_t        active_cfg = '0;
	xlat_t       pending_xlat[$];
	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	int unsigned rx_wait = 0;
	bit          idle_on = 1'b1;
	bit          long_hold_req = 1'b0;

	package_block_address_translator DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic logic [31:0] tables_passed(input logic [31:0] l, input logic [31:0] span,
			input logic dbl);
		logic [31:0] n;
		n = (l + span) / span;
		if (active_cfg.is_con_package) begin
			n = n << dbl;
		end
		return n;
	endfunction

	function automatic xlat_t translate_block(input logic [23:0] lb);
		logic [31:0] l;
		logic [31:0] rounded;
		logic [31:0] phys;
		logic [31:0] tbl;
		logic [31:0] spacing;
		logic [37:0] base;
		logic        dbl;
		xlat_t       r;
		l       = {8'd0, lb};
		rounded = active_cfg.header_bytes + HDR_ROUND;
		base    = 38'(rounded & 32'h0000_F000);
		if ((rounded & SHIFT_MASK) == SHIFT_MASK) begin
			dbl = 1'b1;
		end else begin
			dbl = ~active_cfg.separation_bit;
		end
		phys = l + tables_passed(l, 32'(SPAN0), dbl);
		if (l >= 32'(SPAN0)) begin
			phys += tables_passed(l, 32'(SPAN1), dbl);
			if (l >= 32'(SPAN1)) begin
				phys += tables_passed(l, 32'(SPAN2), dbl);
			end
		end
		spacing = active_cfg.hash_table_shift ? 32'(SPACING_TWO) : 32'(SPACING_ONE);
		tbl = (l / 32'(SPAN0)) * spacing;
		if (l >= 32'(SPAN0)) begin
			tbl += ((l / 32'(SPAN1)) + 32'd1) << active_cfg.hash_table_shift;
			if (l >= 32'(SPAN1)) begin
				tbl += 32'd1 << active_cfg.hash_table_shift;
			end
		end
		r.blk = phys[24:0];
		if (phys >= 32'(BLOCK_LIMIT)) begin
			r.data_ofs = '0;
			r.data_ok  = 1'b0;
		end else begin
			r.data_ofs = base + (38'(phys) << 12);
			r.data_ok  = 1'b1;
		end
		if (tbl >= 32'(BLOCK_LIMIT)) begin
			r.rec_ofs = '0;
			r.rec_ok  = 1'b0;
		end else begin
			r.rec_ofs = base + (38'(tbl) << 12) + 38'((l % 32'(SPAN0)) * 32'(REC_BYTES));
			r.rec_ok  = 1'b1;
		end
		return r;
	endfunction

	function automatic logic [23:0] pick_block();
		logic [31:0] v;
		case ($urandom_range(0, 7))
			0: begin
				v = $urandom_range(16400000, 32'h00FF_FFFF);
			end
			1: begin
				v = $urandom_range(0, 30000);
			end
			2: begin
				v = 32'(SPAN0) * $urandom_range(1, 98689) - $urandom_range(0, 1);
			end
			3: begin
				v = 32'(SPAN1) * $urandom_range(1, 580) - $urandom_range(0, 1);
			end
			default: begin
				v = $urandom();
			end
		endcase
		return v[23:0];
	endfunction

	function automatic cfg_t pick_setting();
		cfg_t c;
		case ($urandom_range(0, 3))
			0: c.header_bytes = $urandom();
			1: c.header_bytes = $urandom_range(0, 32'h0001_FFFF);
			2: c.header_bytes = 32'hFFFF_0000 | $urandom_range(0, 32'h0000_FFFF);
			default: c.header_bytes = 32'h0000_A001 + $urandom_range(0, 32'h0000_0FFE);
		endcase
		c.is_con_package   = 1'($urandom_range(0, 1));
		c.separation_bit   = 1'($urandom_range(0, 1));
		c.hash_table_shift = 1'($urandom_range(0, 1));
		return c;
	endfunction

	task automatic report_field(input string field, input logic [37:0] want,
			input logic [37:0] got);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("mismatch %s: expected 0x%0h, got 0x%0h", field, want, got);
		end
	endtask

	task automatic drain();
		while (pending_xlat.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic send_block(input logic [23:0] lb, input xlat_t want);
		int unsigned gap;
		if (idle_on && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 17);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= lb;
		do @(posedge clk); while (!s_tready);
		pending_xlat = {pending_xlat, want};
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic apply_setting(input cfg_t c);
		if ($urandom_range(0, 1)) begin
			put_reg(REG_UNUSED, $urandom());
		end
		put_reg(REG_HEADER_BYTES, c.header_bytes);
		put_reg(REG_IS_CON_PACKAGE, {31'd0, c.is_con_package});
		put_reg(REG_SEPARATION_BIT, {31'd0, c.separation_bit});
		put_reg(REG_HASH_TABLE_SHIFT, {31'd0, c.hash_table_shift});
		cfg_valid <= 1'b0;
		active_cfg = c;
	endtask

	always @(posedge clk) begin
		if (rx_wait != 0) begin
			rx_wait--;
			if (rx_wait == 0) begin
				m_tready <= 1'b1;
			end
		end else if (long_hold_req) begin
			long_hold_req = 1'b0;
			rx_wait = LONG_HOLD;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			rx_wait = $urandom_range(1, 17);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		xlat_t got;
		xlat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[102:0];
			if (pending_xlat.size() == 0) begin
				report_field("unexpected beat", '0, 38'(got.blk));
			end else begin
				want = pending_xlat.pop_front();
				if (got.blk !== want.blk)
					report_field("physical_block", 38'(want.blk), 38'(got.blk));
				if (got.data_ofs !== want.data_ofs)
					report_field("data_byte_offset", want.data_ofs, got.data_ofs);
				if (got.data_ok !== want.data_ok)
					report_field("data_offset_valid", 38'(want.data_ok), 38'(got.data_ok));
				if (got.rec_ofs !== want.rec_ofs)
					report_field("record_byte_offset", want.rec_ofs, got.rec_ofs);
				if (got.rec_ok !== want.rec_ok)
					report_field("record_offset_valid", 38'(want.rec_ok), 38'(got.rec_ok));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL package_block_address_translator");
			$finish;
		end
	end

	initial begin
		dir_row_t rows[$];
		cfg_t     fixed_settings[4];
		cfg_t     c;
		logic [23:0] lb;

		// rows with typed results assume the reset register values
		rows = '{
			'{24'h000000, 1'b1, '{1'b1, 38'd0, 1'b1, 38'd4096, 25'd1}},
			'{24'd169, 1'b1, '{1'b1, 38'd4056, 1'b1, 38'd696320, 25'd170}},
			'{24'd170, 1'b1, '{1'b1, 38'd704512, 1'b1, 38'd708608, 25'd173}},
			'{24'hFFFFFF, 1'b1, '{1'b0, 38'd0, 1'b0, 38'd0, 25'd16876490}},
			'{24'd171, 1'b0, '0},
			'{24'd28899, 1'b0, '0},
			'{24'd28900, 1'b0, '0},
			'{24'd4912999, 1'b0, '0},
			'{24'd4913000, 1'b0, '0},
			'{24'd16678450, 1'b0, '0},
			'{24'd16678600, 1'b0, '0},
			'{24'h7FFFFF, 1'b0, '0},
			'{24'h800000, 1'b0, '0},
			'{24'hAAAAAA, 1'b0, '0},
			'{24'h555555, 1'b0, '0},
			'{24'hFFFFFE, 1'b0, '0}
		};
		fixed_settings[0] = '{32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1};  // header sum wraps
		fixed_settings[1] = '{32'h0000_A001, 1'b1, 1'b1, 1'b0};  // mask forces doubling
		fixed_settings[2] = '{32'hFFFF_F000, 1'b0, 1'b1, 1'b1};
		fixed_settings[3] = '{32'h0000_1000, 1'b1, 1'b1, 1'b1};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int unsigned ph = 0; ph < NUM_SETTINGS; ph++) begin
			if (ph != 0) begin
				s_tvalid <= 1'b0;
				drain();
				c = (ph <= 4) ? fixed_settings[ph-1] : pick_setting();
				apply_setting(c);
			end
			idle_on = !(ph == 5 || ph == NUM_SETTINGS - 1);
			if (ph == 2) begin
				long_hold_req = 1'b1;
			end
			if (ph == 0) begin
				foreach (rows[i]) begin
					send_block(rows[i].lb,
						rows[i].typed ? rows[i].want : translate_block(rows[i].lb));
				end
			end
			for (int unsigned k = 0; k < ITEMS_PER_SET; k++) begin
				lb = pick_block();
				send_block(lb, translate_block(lb));
			end
		end
		s_tvalid <= 1'b0;
		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_xlat.size() == 0) begin
			$display("PASS package_block_address_translator");
		end else begin
			$display("FAIL package_block_address_translator");
		end
		$finish;
	end

endmodule

`default_nettype wire
